[rtl/core/pwil_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the progress watchdog with idle leases.
// No dependencies; used by every module of the block but pwil_ram.
package pwil_pkg;

   // Opcodes of an input item
   localparam logic [2:0] OP_TICK     = 3'd0;
   localparam logic [2:0] OP_PROGRESS = 3'd1;
   localparam logic [2:0] OP_TAKE     = 3'd2;
   localparam logic [2:0] OP_RELEASE  = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;

   // Result status codes
   localparam logic [2:0] STAT_OK          = 3'd0;
   localparam logic [2:0] STAT_STALL_FIRED = 3'd1;
   localparam logic [2:0] STAT_DUP_OWNER   = 3'd2;
   localparam logic [2:0] STAT_BAD_OWNER   = 3'd3;
   localparam logic [2:0] STAT_TABLE_FULL  = 3'd4;
   localparam logic [2:0] STAT_HALTED      = 3'd5;

   localparam logic [31:0] LIMIT_RESET = 32'd20000;

   localparam int OWNER_W = 16;
   localparam int LEN_W   = 32;
   localparam int CYC_W   = 40;
   localparam int END_W   = 41;
   localparam int CNT_W   = 32;
   localparam int ENTRY_W = OWNER_W + END_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CLS_TICK,
      CLS_PROGRESS,
      CLS_TAKE,
      CLS_RELEASE,
      CLS_CLEAR,
      CLS_NOP
   } cls_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [OWNER_W-1:0] owner_id;
      logic [LEN_W-1:0]   lease_cycles;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [CYC_W-1:0] cycle_now;
      logic [CYC_W-1:0] since_progress;
      logic [CYC_W-1:0] lease_horizon;
      logic [CNT_W-1:0] progress_tally;
   } rsp_type;

   // Classified item as it sits in the queue
   typedef struct packed {
      cls_type            cls;
      logic               owner_zero;
      logic [OWNER_W-1:0] owner;
      logic [LEN_W-1:0]   lease_cycles;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } q_wr_type;

   typedef struct packed {
      logic     empty;
      item_type head;
   } q_rd_type;

endpackage

[rtl/core/progress_watchdog_with_idle_leases.sv]
`timescale 1ns / 1ps
// Top level of the progress watchdog with idle leases.
// Depends on pwil_pkg, pwil_front, pwil_queue and pwil_back.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   req_    | in        | req_valid/req_stall| pwil_pkg::req_type
//   rsp_    | out       | rsp_valid/rsp_stall| pwil_pkg::rsp_type
//   csr_    | in        | csr_valid/csr_ready| silence_limit, 32 bits
//
// In the back end an item is popped, each lease slot is read in turn through the single slot
// RAM port, the last read lands, and the item then commits and loads the result register
// unless the previous result still waits on rsp_stall.
// The front register and the two-entry queue take up to three more items while the
// back end works or a result waits on rsp_stall.
// Sync active-high reset clears lease valid bits and counters, loads limit 20000.
module progress_watchdog_with_idle_leases #(
   parameter int LEASE_SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pwil_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pwil_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pwil_pkg::CNT_W-1:0] csr_data
);

   // Silence limit register; zero turns firing off
   logic [pwil_pkg::CNT_W-1:0] silence_limit_ff, silence_limit_in;

   pwil_pkg::q_wr_type q_wr;
   pwil_pkg::q_rd_type q_rd;
   logic               q_full;
   logic               q_pop;

   // Writes are taken in any cycle; software must only write while idle, which the block does not enforce
   assign csr_ready        = 1'b1;
   assign silence_limit_in = (csr_valid && csr_ready) ? csr_data : silence_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_limit_ff <= pwil_pkg::LIMIT_RESET;
      end else begin
         silence_limit_ff <= silence_limit_in;
      end
   end

   // Front end: request register and opcode classification
   pwil_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_wr      (q_wr),
      .q_full    (q_full)
   );

   // Decoupling queue so the two halves stall independently
   pwil_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   // Back end: lease scan, state update and result register
   pwil_back #(
      .LEASE_SLOTS (LEASE_SLOTS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .silence_limit (silence_limit_ff),
      .q_rd          (q_rd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   // Last progress never runs ahead of the tick count
   a_gap_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.since_progress <= rsp_data.cycle_now)
      else $error("since_progress exceeds cycle_now");

   // A fired stall needs real silence and a cycle past every lease
   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == pwil_pkg::STAT_STALL_FIRED) |->
      (rsp_data.since_progress != '0 && rsp_data.cycle_now > rsp_data.lease_horizon))
      else $error("stall fired without silence or inside a lease");

   // Queue occupancy flags stay consistent
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_rd.empty))
      else $error("queue reports full and empty together");

   // Nothing leaves the queue that was not there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_rd.empty)
      else $error("pop from empty queue");

endmodule

[rtl/core/pwil_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwil_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pwil_front.sv]
`timescale 1ns / 1ps
// Front end: input register that takes request transfers and classifies them.
// Depends on pwil_pkg.
module pwil_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  pwil_pkg::req_type  req_data,
   output pwil_pkg::q_wr_type q_wr,
   input  logic               q_full
);

   logic               fr_valid_ff, fr_valid_in;
   pwil_pkg::item_type fr_item_ff, fr_item_in;
   pwil_pkg::cls_type  cls;
   logic               accept;
   logic               push;

   always_comb begin
      unique case (req_data.opcode)
         pwil_pkg::OP_TICK:     cls = pwil_pkg::CLS_TICK;
         pwil_pkg::OP_PROGRESS: cls = pwil_pkg::CLS_PROGRESS;
         pwil_pkg::OP_TAKE:     cls = pwil_pkg::CLS_TAKE;
         pwil_pkg::OP_RELEASE:  cls = pwil_pkg::CLS_RELEASE;
         pwil_pkg::OP_CLEAR:    cls = pwil_pkg::CLS_CLEAR;
         default:               cls = pwil_pkg::CLS_NOP;
      endcase
   end

   assign push      = fr_valid_ff && !q_full;
   assign req_stall = fr_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_item_in  = fr_item_ff;
      if (accept) begin
         fr_valid_in             = 1'b1;
         fr_item_in.cls          = cls;
         fr_item_in.owner_zero   = (req_data.owner_id == '0);
         fr_item_in.owner        = req_data.owner_id;
         fr_item_in.lease_cycles = req_data.lease_cycles;
      end else if (push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_item_ff <= fr_item_in;
   end

   assign q_wr.push = push;
   assign q_wr.item = fr_item_ff;

endmodule

[rtl/core/pwil_queue.sv]
`timescale 1ns / 1ps
// Short FIFO of classified items between the front end and the back end.
// Depends on pwil_pkg.
module pwil_queue (
   input  logic               clock,
   input  logic               reset,
   input  pwil_pkg::q_wr_type q_wr,
   output logic               q_full,
   input  logic               q_pop,
   output pwil_pkg::q_rd_type q_rd
);

   localparam int PW = pwil_pkg::QUEUE_PTR_W;
   localparam logic [PW-1:0] LAST_PTR   = PW'(pwil_pkg::QUEUE_DEPTH - 1);
   localparam logic [PW:0]   FULL_COUNT = (PW + 1)'(pwil_pkg::QUEUE_DEPTH);

   pwil_pkg::item_type mem_ff [pwil_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_wr.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (q_wr.push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !q_wr.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (q_wr.push) begin
         mem_ff[wr_ptr_ff] <= q_wr.item;
      end
   end

   assign q_full     = (count_ff == FULL_COUNT);
   assign q_rd.empty = (count_ff == '0);
   assign q_rd.head  = mem_ff[rd_ptr_ff];

endmodule

[rtl/core/pwil_back.sv]
`timescale 1ns / 1ps
// Back end: scans the lease table one slot per cycle, then commits the item
// and loads the result register. Depends on pwil_pkg and pwil_ram.
module pwil_back #(
   parameter int LEASE_SLOTS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [pwil_pkg::CNT_W-1:0] silence_limit,
   input  pwil_pkg::q_rd_type         q_rd,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pwil_pkg::rsp_type          rsp_data
);

   localparam int IDX_W   = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;
   localparam int CYC_W   = pwil_pkg::CYC_W;
   localparam int END_W   = pwil_pkg::END_W;
   localparam int CNT_W   = pwil_pkg::CNT_W;
   localparam int OWNER_W = pwil_pkg::OWNER_W;
   localparam int ENTRY_W = pwil_pkg::ENTRY_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LEASE_SLOTS - 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT, S_DONE} state_type;

   state_type              state_ff, state_in;
   pwil_pkg::item_type     item_ff, item_in;
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   chk_en_ff, chk_en_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [LEASE_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [END_W-1:0]       hmax_ff, hmax_in;
   logic                   dup_ff, dup_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [CYC_W-1:0]       cycle_ff, cycle_in;
   logic [CYC_W-1:0]       last_ff, last_in;
   logic                   pending_ff, pending_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic                   halted_ff, halted_in;
   logic [CYC_W-1:0]       inc_ff, inc_in;
   logic [END_W-1:0]       end_ff, end_in;
   logic [CYC_W-1:0]       gap_tick_ff, gap_tick_in;
   logic [CYC_W-1:0]       gap_now_ff, gap_now_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pwil_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic                   ram_wr_en;
   logic [ENTRY_W-1:0]     ram_q;
   logic [OWNER_W-1:0]     rd_owner;
   logic [END_W-1:0]       rd_end;
   logic                   owner_match;
   logic                   live;
   logic [2:0]             stat_sel;
   logic [CYC_W-1:0]       gap_sel;
   logic [END_W-1:0]       h_sel;
   logic [CNT_W-1:0]       total_inc;

   pwil_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LEASE_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data ({item_ff.owner, end_ff}),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_q)
   );

   assign rd_owner    = ram_q[ENTRY_W-1:END_W];
   assign rd_end      = ram_q[END_W-1:0];
   assign owner_match = (rd_owner == item_ff.owner);
   assign total_inc   = (total_ff == '1) ? total_ff : total_ff + 1'b1;
   assign live        = !(halted_ff && (item_ff.cls == pwil_pkg::CLS_TICK ||
                                        item_ff.cls == pwil_pkg::CLS_PROGRESS ||
                                        item_ff.cls == pwil_pkg::CLS_TAKE ||
                                        item_ff.cls == pwil_pkg::CLS_RELEASE));

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      scan_idx_in   = scan_idx_ff;
      chk_en_in     = 1'b0;
      chk_idx_in    = chk_idx_ff;
      slot_valid_in = slot_valid_ff;
      hmax_in       = hmax_ff;
      dup_in        = dup_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cycle_in      = cycle_ff;
      last_in       = last_ff;
      pending_in    = pending_ff;
      total_in      = total_ff;
      halted_in     = halted_ff;
      inc_in        = inc_ff;
      end_in        = end_ff;
      gap_tick_in   = inc_ff - last_ff;
      gap_now_in    = cycle_ff - last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      ram_wr_en     = 1'b0;
      stat_sel      = pwil_pkg::STAT_OK;
      gap_sel       = gap_now_ff;
      h_sel         = hmax_ff;

      // One slot's read data lands per cycle behind the scan address
      if (chk_en_ff) begin
         if (slot_valid_ff[chk_idx_ff]) begin
            if (item_ff.cls == pwil_pkg::CLS_RELEASE && !halted_ff &&
                owner_match && !found_ff) begin
               // released slot drops out of the horizon
               found_in   = 1'b1;
               hit_idx_in = chk_idx_ff;
            end else if (rd_end > hmax_ff) begin
               hmax_in = rd_end;
            end
            if (item_ff.cls == pwil_pkg::CLS_TAKE && owner_match) begin
               dup_in = 1'b1;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!q_rd.empty) begin
               q_pop         = 1'b1;
               item_in       = q_rd.head;
               scan_idx_in   = '0;
               hmax_in       = '0;
               dup_in        = 1'b0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               inc_in        = (cycle_ff == '1) ? cycle_ff : cycle_ff + 1'b1;
               end_in        = {1'b0, cycle_ff} + END_W'(q_rd.head.lease_cycles)
                               + END_W'(1);
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            chk_en_in  = 1'b1;
            chk_idx_in = scan_idx_ff;
            if (scan_idx_ff == LAST_IDX) begin
               state_in = S_WAIT;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         S_WAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if (!live) begin
                  stat_sel = pwil_pkg::STAT_HALTED;
               end else begin
                  unique case (item_ff.cls)
                     pwil_pkg::CLS_TICK: begin
                        cycle_in = inc_ff;
                        if (pending_ff) begin
                           pending_in = 1'b0;
                           last_in    = inc_ff;
                           gap_sel    = '0;
                        end else begin
                           gap_sel = gap_tick_ff;
                           if (silence_limit != '0 &&
                               gap_tick_ff > CYC_W'(silence_limit) &&
                               {1'b0, inc_ff} > hmax_ff) begin
                              halted_in = 1'b1;
                              stat_sel  = pwil_pkg::STAT_STALL_FIRED;
                           end
                        end
                     end
                     pwil_pkg::CLS_PROGRESS: begin
                        total_in   = total_inc;
                        pending_in = 1'b1;
                     end
                     pwil_pkg::CLS_TAKE: begin
                        if (item_ff.owner_zero) begin
                           stat_sel = pwil_pkg::STAT_BAD_OWNER;
                        end else if (dup_ff) begin
                           stat_sel = pwil_pkg::STAT_DUP_OWNER;
                        end else if (!free_found_ff) begin
                           stat_sel = pwil_pkg::STAT_TABLE_FULL;
                        end else begin
                           ram_wr_en                  = 1'b1;
                           slot_valid_in[free_idx_ff] = 1'b1;
                           if (end_ff > hmax_ff) begin
                              h_sel = end_ff;
                           end
                        end
                     end
                     pwil_pkg::CLS_RELEASE: begin
                        if (found_ff) begin
                           slot_valid_in[hit_idx_ff] = 1'b0;
                           total_in                  = total_inc;
                           pending_in                = 1'b1;
                        end
                     end
                     pwil_pkg::CLS_CLEAR: begin
                        slot_valid_in = '0;
                        last_in       = '0;
                        pending_in    = 1'b0;
                        total_in      = '0;
                        halted_in     = 1'b0;
                        h_sel         = '0;
                        gap_sel       = cycle_ff;
                     end
                     pwil_pkg::CLS_NOP: begin
                     end
                  endcase
               end
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = stat_sel;
               rsp_data_in.cycle_now       = cycle_in;
               rsp_data_in.since_progress  = gap_sel;
               rsp_data_in.lease_horizon   = h_sel[END_W-1] ? '1 : h_sel[CYC_W-1:0];
               rsp_data_in.progress_tally  = total_in;
               state_in                    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_en_ff     <= 1'b0;
         slot_valid_ff <= '0;
         cycle_ff      <= '0;
         last_ff       <= '0;
         pending_ff    <= 1'b0;
         total_ff      <= '0;
         halted_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_en_ff     <= chk_en_in;
         slot_valid_ff <= slot_valid_in;
         cycle_ff      <= cycle_in;
         last_ff       <= last_in;
         pending_ff    <= pending_in;
         total_ff      <= total_in;
         halted_ff     <= halted_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff       <= item_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      hmax_ff       <= hmax_in;
      dup_ff        <= dup_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      inc_ff        <= inc_in;
      end_ff        <= end_in;
      gap_tick_ff   <= gap_tick_in;
      gap_now_ff    <= gap_now_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/progress_watchdog_with_idle_leases_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for progress_watchdog_with_idle_leases: directed lease/stall
// cases, then random traffic under varied idling. Depends on pwil_pkg and the RTL.
module progress_watchdog_with_idle_leases_test;

   localparam int LEASE_SLOTS   = 8;
   localparam int TAIL_CYCLES   = 60;    // a few back-end passes
   localparam int QUIET_LIMIT   = 4000;  // cycles with no transfer before giving up
   localparam int CHUNK_ITEMS   = 100;
   localparam int CYC_W         = pwil_pkg::CYC_W;
   localparam int END_W         = pwil_pkg::END_W;
   localparam int CNT_W         = pwil_pkg::CNT_W;
   localparam int OWNER_W       = pwil_pkg::OWNER_W;
   localparam int LEN_W         = pwil_pkg::LEN_W;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pwil_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   pwil_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CNT_W-1:0]  csr_data = '0;

   progress_watchdog_with_idle_leases #(.LEASE_SLOTS(LEASE_SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Watchdog model state
   // ---------------------------------------------------------------------
   logic [31:0]      silence_limit = pwil_pkg::LIMIT_RESET;
   logic [CYC_W-1:0] tick_count    = '0;
   logic [CYC_W-1:0] last_progress = '0;
   bit               progress_seen = 1'b0;
   logic [CNT_W-1:0] progress_count = '0;
   bit               wd_halted     = 1'b0;
   bit               lease_held [LEASE_SLOTS];
   logic [OWNER_W-1:0] lease_owner [LEASE_SLOTS];
   logic [END_W-1:0]   lease_end   [LEASE_SLOTS];

   pwil_pkg::rsp_type due_reports[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      limit_chunk = 0;

   function automatic logic [END_W-1:0] lease_horizon();
      logic [END_W-1:0] h;
      h = '0;
      for (int i = 0; i < LEASE_SLOTS; i++)
         if (lease_held[i] && lease_end[i] > h) h = lease_end[i];
      return h;
   endfunction

   function automatic void count_progress();
      if (progress_count != '1) progress_count++;
      progress_seen = 1'b1;
   endfunction

   function automatic void clear_watchdog();
      last_progress  = '0;
      progress_seen  = 1'b0;
      progress_count = '0;
      wd_halted      = 1'b0;
      for (int i = 0; i < LEASE_SLOTS; i++) lease_held[i] = 1'b0;
   endfunction

   // Applies one item to the model and returns the report it should produce.
   function automatic pwil_pkg::rsp_type watchdog_step(input pwil_pkg::req_type it);
      pwil_pkg::rsp_type r;
      logic [END_W-1:0]  h;
      int                free_slot;
      bit                dup;
      r = '0;
      r.status = pwil_pkg::STAT_OK;
      free_slot = -1;
      dup = 1'b0;
      if (wd_halted && it.opcode <= pwil_pkg::OP_RELEASE) begin
         r.status = pwil_pkg::STAT_HALTED;
      end else begin
         unique case (it.opcode)
            pwil_pkg::OP_TICK: begin
               if (tick_count != '1) tick_count++;
               if (progress_seen) begin
                  progress_seen = 1'b0;
                  last_progress = tick_count;
               end else if (silence_limit != 0 &&
                            (tick_count - last_progress) > CYC_W'(silence_limit) &&
                            END_W'(tick_count) > lease_horizon()) begin
                  wd_halted = 1'b1;
                  r.status = pwil_pkg::STAT_STALL_FIRED;
               end
            end
            pwil_pkg::OP_PROGRESS: count_progress();
            pwil_pkg::OP_TAKE: begin
               if (it.owner_id == '0) begin
                  r.status = pwil_pkg::STAT_BAD_OWNER;
               end else begin
                  for (int i = 0; i < LEASE_SLOTS; i++) begin
                     if (lease_held[i]) begin
                        if (lease_owner[i] == it.owner_id) dup = 1'b1;
                     end else if (free_slot < 0) begin
                        free_slot = i;
                     end
                  end
                  if (dup) begin
                     r.status = pwil_pkg::STAT_DUP_OWNER;
                  end else if (free_slot < 0) begin
                     r.status = pwil_pkg::STAT_TABLE_FULL;
                  end else begin
                     lease_held[free_slot]  = 1'b1;
                     lease_owner[free_slot] = it.owner_id;
                     lease_end[free_slot]   = END_W'(tick_count) + END_W'(it.lease_cycles)
                                              + END_W'(1);
                  end
               end
            end
            pwil_pkg::OP_RELEASE: begin
               for (int i = 0; i < LEASE_SLOTS; i++) begin
                  if (lease_held[i] && lease_owner[i] == it.owner_id) begin
                     lease_held[i] = 1'b0;
                     count_progress();
                     break;
                  end
               end
            end
            pwil_pkg::OP_CLEAR: clear_watchdog();
            default: ;  // spare opcodes are ignored
         endcase
      end
      h = lease_horizon();
      r.cycle_now      = tick_count;
      r.since_progress = tick_count - last_progress;
      r.lease_horizon  = h[END_W-1] ? '1 : h[CYC_W-1:0];
      r.progress_tally = progress_count;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------
   function automatic pwil_pkg::req_type make_item(input logic [2:0] op,
                                                   input logic [OWNER_W-1:0] owner,
                                                   input logic [LEN_W-1:0] len);
      pwil_pkg::req_type it;
      it.opcode = op;
      it.owner_id = owner;
      it.lease_cycles = len;
      return it;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer,
   // leaving valid high so back-to-back items need no toggle.
   task automatic send_item(input pwil_pkg::req_type it);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      due_reports.insert(due_reports.size(), watchdog_step(it));
      @(negedge clock);
   endtask

   // Stop sending and wait until every report has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      silence_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      pwil_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            report_mismatch("report with none due, status", 64'(rsp_data.status), 64'd0);
         end else begin
            want = due_reports.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.cycle_now != want.cycle_now)
               report_mismatch("cycle_now", 64'(rsp_data.cycle_now),
                               64'(want.cycle_now));
            if (rsp_data.since_progress != want.since_progress)
               report_mismatch("since_progress", 64'(rsp_data.since_progress),
                               64'(want.since_progress));
            if (rsp_data.lease_horizon != want.lease_horizon)
               report_mismatch("lease_horizon", 64'(rsp_data.lease_horizon),
                               64'(want.lease_horizon));
            if (rsp_data.progress_tally != want.progress_tally)
               report_mismatch("progress_tally", 64'(rsp_data.progress_tally),
                               64'(want.progress_tally));
         end
      end
   end

   // Give up when no channel has moved a transfer for too long.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("progress_watchdog_with_idle_leases_test: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Reset limit of 20000: ticks never fire; spare opcodes pass through.
   task automatic test_reset_defaults();
      send_item(make_item(pwil_pkg::OP_TICK, '0, '0));
      send_item(make_item(pwil_pkg::OP_PROGRESS, '0, '0));
      send_item(make_item(pwil_pkg::OP_TICK, '0, '0));
      send_item(make_item(pwil_pkg::OP_CLEAR + 3'd1, '1, '1));
      send_item(make_item(pwil_pkg::OP_CLEAR + 3'd3, '1, '1));
   endtask

   // Bad owner, widest lease, duplicate, full table, releases held and not.
   task automatic test_lease_table();
      send_item(make_item(pwil_pkg::OP_TAKE, '0, 32'd5));
      send_item(make_item(pwil_pkg::OP_TAKE, '1, '1));
      send_item(make_item(pwil_pkg::OP_TAKE, '1, 32'd3));
      for (int k = 1; k < LEASE_SLOTS; k++)
         send_item(make_item(pwil_pkg::OP_TAKE, OWNER_W'(k), LEN_W'(k)));
      send_item(make_item(pwil_pkg::OP_TAKE, OWNER_W'(LEASE_SLOTS), '0));
      send_item(make_item(pwil_pkg::OP_RELEASE, '1, '0));
      send_item(make_item(pwil_pkg::OP_RELEASE, '0, '0));
      send_item(make_item(pwil_pkg::OP_CLEAR, '0, '0));
   endtask

   // Limit of one: a short lease holds off the stall, then it fires and the
   // block stays halted until a clear.
   task automatic test_stall_and_halt();
      write_limit(32'd1);
      send_item(make_item(pwil_pkg::OP_TAKE, 16'd1, 32'd1));
      repeat (3) send_item(make_item(pwil_pkg::OP_TICK, '0, '0));
      send_item(make_item(pwil_pkg::OP_RELEASE, 16'd1, '0));
      send_item(make_item(pwil_pkg::OP_CLEAR, '0, '0));
   endtask

   function automatic pwil_pkg::req_type random_item();
      pwil_pkg::req_type it;
      int                pick;
      pick = $urandom_range(0, 99);
      it.owner_id = ($urandom_range(0, 9) == 0) ? OWNER_W'($urandom)
                                                 : OWNER_W'($urandom_range(1, 12));
      it.lease_cycles = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                                     : LEN_W'($urandom_range(0, 15));
      if (wd_halted && pick < 35)  it.opcode = pwil_pkg::OP_CLEAR;
      else if (pick < 45)          it.opcode = pwil_pkg::OP_TICK;
      else if (pick < 60)          it.opcode = pwil_pkg::OP_PROGRESS;
      else if (pick < 75)          it.opcode = pwil_pkg::OP_TAKE;
      else if (pick < 90)          it.opcode = pwil_pkg::OP_RELEASE;
      else if (pick < 94)          it.opcode = pwil_pkg::OP_CLEAR;
      else it.opcode = pwil_pkg::OP_CLEAR + 3'($urandom_range(1, 3));
      return it;
   endfunction

   // Mostly tight limits so stalls fire; chunks 2, 5 are extreme, 8 is as at reset.
   function automatic logic [31:0] next_limit();
      logic [31:0] v;
      unique case (limit_chunk % 6)
         2:       v = 32'd0;
         5:       v = '1;
         default: v = 32'($urandom_range(1, 8));
      endcase
      if (limit_chunk == 8) v = pwil_pkg::LIMIT_RESET;
      limit_chunk++;
      return v;
   endfunction

   task automatic test_random_traffic(input int n_items, input int idle_pct,
                                      input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % CHUNK_ITEMS == 0) write_limit(next_limit());
         send_item(random_item());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_lease_table();
      test_stall_and_halt();
      test_random_traffic(300, 14, 45);
      test_random_traffic(300, 45, 14);
      test_random_traffic(300, 0, 0);

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("progress_watchdog_with_idle_leases_test: done, clean");
      else
         $display("progress_watchdog_with_idle_leases_test: done, errors");
      $finish;
   end

endmodule
